// ===== rtl/rss_pkg.sv =====
// rss_pkg: shared types and constants of the rgb 3x3 sharpen stream.
// Used by rss_line_store, rss_sharpen and rgb_sharpen_3x3_stream; no dependencies.

package rss_pkg;

  localparam int unsigned MaxWidth   = 2048;
  localparam int unsigned MaxHeight  = 4096;
  localparam int unsigned MinDim     = 3;
  localparam int unsigned AddrW      = $clog2(MaxWidth);
  localparam int unsigned ChanW      = 8;
  localparam int unsigned NumChan    = 3;
  localparam int unsigned WinSize    = 9;
  localparam int unsigned CentreTap  = 4;
  localparam int unsigned CentreGain = 9;
  localparam int unsigned FrameWidthW  = 12;
  localparam int unsigned FrameHeightW = 13;
  localparam int unsigned ColW       = 11;
  localparam int unsigned RowW       = 12;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 13;
  localparam logic [FrameWidthW-1:0]  WidthReset  = 12'd640;
  localparam logic [FrameHeightW-1:0] HeightReset = 13'd480;

  typedef enum logic [CfgIdxW-1:0] {
    RegFrameWidth  = 2'd0,
    RegFrameHeight = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  // row-major 3x3 window, top row first, newest column at the high index of each row
  typedef pixel_t [WinSize-1:0] window_t;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW-1:0] rd_addr;
    logic             wr_en;
    logic [AddrW-1:0] wr_addr;
  } ls_ctrl_t;

endpackage

// ===== rtl/rss_line_store.sv =====
// rss_line_store: the two line memories (row two above and row directly above).
// One write port and one registered read port each; uses rss_pkg.

module rss_line_store (
  input  logic             clk_i,
  input  rss_pkg::ls_ctrl_t ctrl_i,
  input  rss_pkg::pixel_t  wr_upper_i,
  input  rss_pkg::pixel_t  wr_middle_i,
  output rss_pkg::pixel_t  rd_upper_o,
  output rss_pkg::pixel_t  rd_middle_o
);

  rss_pkg::pixel_t upper_mem  [rss_pkg::MaxWidth];
  rss_pkg::pixel_t middle_mem [rss_pkg::MaxWidth];
  rss_pkg::pixel_t rd_upper_q;
  rss_pkg::pixel_t rd_middle_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      upper_mem[ctrl_i.wr_addr]  <= wr_upper_i;
      middle_mem[ctrl_i.wr_addr] <= wr_middle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_upper_q  <= upper_mem[ctrl_i.rd_addr];
      rd_middle_q <= middle_mem[ctrl_i.rd_addr];
    end
  end

  assign rd_upper_o  = rd_upper_q;
  assign rd_middle_o = rd_middle_q;

endmodule

// ===== rtl/rss_sharpen.sv =====
// rss_sharpen: sharpen kernel over a 3x3 window, per channel, saturated to 0..255.
// Purely combinational; uses rss_pkg.

module rss_sharpen (
  input  rss_pkg::window_t win_i,
  output rss_pkg::pixel_t  pix_o
);

  localparam int unsigned NbrW  = rss_pkg::ChanW + 3;
  localparam int unsigned CtrW  = rss_pkg::ChanW + 4;
  localparam int unsigned DiffW = CtrW + 1;

  logic [rss_pkg::NumChan*rss_pkg::ChanW-1:0] res;

  always_comb begin
    logic [NbrW-1:0]         nbr_sum;
    logic [CtrW-1:0]         centre;
    logic signed [DiffW-1:0] diff;
    res = '0;
    for (int ch = 0; ch < rss_pkg::NumChan; ch++) begin
      nbr_sum = '0;
      for (int k = 0; k < rss_pkg::WinSize; k++) begin
        if (k != rss_pkg::CentreTap) begin
          nbr_sum = nbr_sum + NbrW'(win_i[k][ch*rss_pkg::ChanW +: rss_pkg::ChanW]);
        end
      end
      centre = CtrW'(win_i[rss_pkg::CentreTap][ch*rss_pkg::ChanW +: rss_pkg::ChanW])
               * CtrW'(rss_pkg::CentreGain);
      diff = $signed({1'b0, centre}) - $signed({2'b00, nbr_sum});
      priority if (diff < 0) begin
        res[ch*rss_pkg::ChanW +: rss_pkg::ChanW] = '0;
      end else if (diff > $signed(DiffW'(255))) begin
        res[ch*rss_pkg::ChanW +: rss_pkg::ChanW] = '1;
      end else begin
        res[ch*rss_pkg::ChanW +: rss_pkg::ChanW] = diff[rss_pkg::ChanW-1:0];
      end
    end
  end

  assign pix_o = rss_pkg::pixel_t'(res);

endmodule

// ===== rtl/rgb_sharpen_3x3_stream.sv =====
// rgb_sharpen_3x3_stream: streaming 3x3 sharpen filter over raster rgb pixels.
// Uses rss_pkg, rss_line_store and rss_sharpen.
//
//   channel | direction | handshake                  | payload
//   cfg     | in        | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i / in_ready_o    | red_in_i, green_in_i, blue_in_i
//   out     | out       | out_valid_o / out_ready_i  | rgb out, out_row_o, out_col_o
//
// one item per cycle sustained while the output does not stall; a result is offered once its
// lower-right neighbour has passed stage 1 (line store read with the item), stage 2 (window
// update) and the kernel into the output register
// interior pixels come out when their lower-right neighbour is taken; borders give none
// reset restores 640x480 and the raster position; line stores are not cleared
// a stall on the output backs up stage by stage to in_ready_o; cfg_ready_o is always high

module rgb_sharpen_3x3_stream (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rss_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [rss_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [rss_pkg::ChanW-1:0]           red_in_i,
  input  logic [rss_pkg::ChanW-1:0]           green_in_i,
  input  logic [rss_pkg::ChanW-1:0]           blue_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [rss_pkg::ChanW-1:0]           red_out_o,
  output logic [rss_pkg::ChanW-1:0]           green_out_o,
  output logic [rss_pkg::ChanW-1:0]           blue_out_o,
  output logic [rss_pkg::RowW-1:0]            out_row_o,
  output logic [rss_pkg::ColW-1:0]            out_col_o
);

  // configuration
  logic [rss_pkg::FrameWidthW-1:0]  frame_width_q;
  logic [rss_pkg::FrameHeightW-1:0] frame_height_q;
  logic [rss_pkg::FrameWidthW-1:0]  width_eff;
  logic [rss_pkg::FrameHeightW-1:0] height_eff;

  // raster position of the next item
  logic [rss_pkg::ColW-1:0] col_q, col_d;
  logic [rss_pkg::RowW-1:0] row_q, row_d;
  logic                     col_last, row_last;

  // stage 1: item plus line store read
  logic                     s1_valid_q;
  logic                     s1_emit_q;
  rss_pkg::pixel_t          s1_pix_q;
  logic [rss_pkg::ColW-1:0] s1_col_q;
  logic [rss_pkg::RowW-1:0] s1_row_q;

  // stage 2: window and position of the filtered pixel
  logic                     s2_valid_q;
  rss_pkg::window_t         win_q, win_d;
  logic [rss_pkg::ColW-1:0] s2_col_q;
  logic [rss_pkg::RowW-1:0] s2_row_q;

  // output register
  logic                     out_valid_q;
  rss_pkg::pixel_t          out_pix_q;
  logic [rss_pkg::ColW-1:0] out_col_q;
  logic [rss_pkg::RowW-1:0] out_row_q;

  logic              in_fire, out_free, s2_adv, s2_free, s1_adv;
  rss_pkg::ls_ctrl_t ls_ctrl;
  rss_pkg::pixel_t   in_pix, rd_upper, rd_middle, sharp_pix;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= rss_pkg::WidthReset;
      frame_height_q <= rss_pkg::HeightReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        rss_pkg::RegFrameWidth:  frame_width_q  <= cfg_data_i[rss_pkg::FrameWidthW-1:0];
        rss_pkg::RegFrameHeight: frame_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (frame_width_q < rss_pkg::FrameWidthW'(rss_pkg::MinDim)) begin
      width_eff = rss_pkg::FrameWidthW'(rss_pkg::MinDim);
    end else if (frame_width_q > rss_pkg::FrameWidthW'(rss_pkg::MaxWidth)) begin
      width_eff = rss_pkg::FrameWidthW'(rss_pkg::MaxWidth);
    end else begin
      width_eff = frame_width_q;
    end
    priority if (frame_height_q < rss_pkg::FrameHeightW'(rss_pkg::MinDim)) begin
      height_eff = rss_pkg::FrameHeightW'(rss_pkg::MinDim);
    end else if (frame_height_q > rss_pkg::FrameHeightW'(rss_pkg::MaxHeight)) begin
      height_eff = rss_pkg::FrameHeightW'(rss_pkg::MaxHeight);
    end else begin
      height_eff = frame_height_q;
    end
  end

  // pipeline flow
  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_adv     = s2_valid_q && out_free;
  assign s2_free    = !s2_valid_q || out_free;
  assign s1_adv     = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s2_free;
  assign in_fire    = in_valid_i && in_ready_o;

  assign in_pix = '{red: red_in_i, green: green_in_i, blue: blue_in_i};

  // raster counters; a position past a new limit wraps at the next advance
  assign col_last = (rss_pkg::FrameWidthW'(col_q) + 1'b1) >= width_eff;
  assign row_last = (rss_pkg::FrameHeightW'(row_q) + 1'b1) >= height_eff;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // line stores: read on accept, write back as the item leaves stage 1
  assign ls_ctrl.rd_en   = in_fire;
  assign ls_ctrl.rd_addr = col_q[rss_pkg::AddrW-1:0];
  assign ls_ctrl.wr_en   = s1_adv;
  assign ls_ctrl.wr_addr = s1_col_q[rss_pkg::AddrW-1:0];

  rss_line_store u_line_store (
    .clk_i       (clk_i),
    .ctrl_i      (ls_ctrl),
    .wr_upper_i  (rd_middle),
    .wr_middle_i (s1_pix_q),
    .rd_upper_o  (rd_upper),
    .rd_middle_o (rd_middle)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_pix_q  <= in_pix;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_emit_q <= (row_q >= rss_pkg::RowW'(2)) && (col_q >= rss_pkg::ColW'(2));
    end
  end

  // window shifts left, new column from the two line stores and the item
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_d[r*3+0] = win_q[r*3+1];
      win_d[r*3+1] = win_q[r*3+2];
    end
    win_d[2] = rd_upper;
    win_d[5] = rd_middle;
    win_d[8] = s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s2_valid_q <= s1_emit_q;
    end else if (s2_adv) begin
      s2_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      win_q    <= win_d;
      s2_col_q <= s1_col_q - 1'b1;
      s2_row_q <= s1_row_q - 1'b1;
    end
  end

  rss_sharpen u_sharpen (
    .win_i (win_q),
    .pix_o (sharp_pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      out_pix_q <= sharp_pix;
      out_col_q <= s2_col_q;
      out_row_q <= s2_row_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_out_o   = out_pix_q.red;
  assign green_out_o = out_pix_q.green;
  assign blue_out_o  = out_pix_q.blue;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;

  // the line store never reads and writes the same entry in one cycle
  a_ls_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ls_ctrl.rd_en && ls_ctrl.wr_en |-> ls_ctrl.rd_addr != ls_ctrl.wr_addr)
    else $error("line store read and write hit the same entry");

  a_col_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && col_last |=> col_q == '0)
    else $error("column counter failed to wrap at end of row");

  a_interior_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_row_o != '0 && out_col_o != '0)
    else $error("result reported for a border pixel");

  a_window_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !out_free |=> s2_valid_q && $stable(win_q))
    else $error("window moved while its result was stalled");

  a_ready_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s2_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

endmodule
